// File: src/dsdk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdk_pkg
// Shared types, codes and helpers of the derivative set and domain kernel.
// ----------------------------------------------------------------------------
package dsdk_pkg;

  localparam int unsigned DIM_W = 3;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned MAP_W = 64;

  localparam logic [DIM_W-1:0] DIM_RESET = 3'd6;

  // Mode codes on the request port
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_DOMAIN = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SET,
    OP_DOMAIN
  } op_t;

  // Classified command as queued between front and back
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] value;
    logic [MAP_W-1:0] marks;
    logic [DIM_W-1:0] dim;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SCAN,
    BK_DRAIN
  } bk_state_t;

  // All ones over the low 2^dim bits; dim is already clamped to 1..6
  function automatic logic [MAP_W-1:0] low_mask(input logic [DIM_W-1:0] dim);
    logic [IDX_W:0] size;
    size = (IDX_W + 1)'(1) << dim;
    if (size[IDX_W]) begin
      return '1;
    end
    return (MAP_W'(1) << size[IDX_W-1:0]) - MAP_W'(1);
  endfunction

endpackage

// File: src/dsdk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdk_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsdk_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/dsdk_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdk_fifo
// Short command queue that decouples the front end from the compute engine.
// ----------------------------------------------------------------------------
module dsdk_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dsdk_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output dsdk_pkg::cmd_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dsdk_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: src/dsdk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdk_front
// Accept requests, hold the dimension register, classify and queue commands.
// ----------------------------------------------------------------------------
module dsdk_front #(
  parameter int MAX_DIM = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dsdk_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     mode,
  input  logic [dsdk_pkg::IDX_W-1:0]     index,
  input  logic [dsdk_pkg::IDX_W-1:0]     entry_value,
  input  logic [dsdk_pkg::MAP_W-1:0]     t_set,
  input  logic                           q_full,
  output logic                           push,
  output dsdk_pkg::cmd_t                 push_cmd
);

  logic [dsdk_pkg::DIM_W-1:0] dimension;
  logic [dsdk_pkg::DIM_W-1:0] dim_eff;
  logic                       accept;
  logic                       known;
  dsdk_pkg::op_t              op;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= dsdk_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dimension <= cfg_data;
    end
  end

  // Clamp to 1..MAX_DIM
  always_comb begin
    if (dimension == '0) begin
      dim_eff = dsdk_pkg::DIM_W'(1);
    end else if (dimension > dsdk_pkg::DIM_W'(MAX_DIM)) begin
      dim_eff = dsdk_pkg::DIM_W'(MAX_DIM);
    end else begin
      dim_eff = dimension;
    end
  end

  always_comb begin
    known = 1'b1;
    op    = dsdk_pkg::OP_LOAD;
    unique case (mode)
      dsdk_pkg::MODE_LOAD: begin
        op = dsdk_pkg::OP_LOAD;
      end
      dsdk_pkg::MODE_SET: begin
        op = dsdk_pkg::OP_SET;
      end
      dsdk_pkg::MODE_DOMAIN: begin
        op = dsdk_pkg::OP_DOMAIN;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Drop unknown modes here; the back end never sees them
  assign push           = accept && known;
  assign push_cmd.op    = op;
  assign push_cmd.index = index;
  assign push_cmd.value = entry_value;
  assign push_cmd.marks = t_set & dsdk_pkg::low_mask(dim_eff);
  assign push_cmd.dim   = dim_eff;

endmodule

// File: src/dsdk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsdk_back
// Compute engine: owns the truth table and scans derivative value sets.
// ----------------------------------------------------------------------------
module dsdk_back #(
  parameter int MAX_DIM = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  dsdk_pkg::cmd_t             head,
  output logic                       pop,
  output logic                       result_valid,
  output logic [dsdk_pkg::MAP_W-1:0] result_bitmap
);

  localparam int AW    = MAX_DIM;
  localparam int DEPTH = 1 << MAX_DIM;

  dsdk_pkg::bk_state_t state;
  dsdk_pkg::bk_state_t state_next;

  dsdk_pkg::op_t              op;
  logic [AW-1:0]              vmask;
  logic [AW-1:0]              head_vmask;
  logic [dsdk_pkg::MAP_W-1:0] marks;
  logic [AW-1:0]              p;
  logic [AW-1:0]              y;
  logic [AW-1:0]              fp;
  logic                       acc_v;
  logic [dsdk_pkg::MAP_W-1:0] sbits;
  logic [dsdk_pkg::MAP_W-1:0] sbits_upd;
  logic [dsdk_pkg::MAP_W-1:0] dom;
  logic [dsdk_pkg::MAP_W-1:0] dom_upd;
  logic [AW-1:0]              t_val;
  logic                       check;
  logic                       last_point;
  logic                       in_table;

  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [AW-1:0] rdata_a;
  logic [AW-1:0] rdata_b;

  // Two copies of the table give f(y) and f(p^y) in the same cycle
  dsdk_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  dsdk_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign head_vmask = AW'(((AW + 1)'(1) << head.dim) - (AW + 1)'(1));

  // Drop loads past the table; no query can ever read them back
  assign in_table = ((head.index | dsdk_pkg::IDX_W'(DEPTH - 1))
                     == dsdk_pkg::IDX_W'(DEPTH - 1));

  assign t_val     = (fp ^ rdata_a ^ rdata_b) & vmask;
  assign sbits_upd = acc_v ? (sbits | (dsdk_pkg::MAP_W'(1) << t_val)) : sbits;
  assign check     = ((marks & ~sbits_upd) == '0);
  assign dom_upd   = dom | (dsdk_pkg::MAP_W'(check) << p);
  assign last_point = (op == dsdk_pkg::OP_SET) || (p == vmask);

  always_comb begin
    state_next = state;
    unique case (state)
      dsdk_pkg::BK_IDLE: begin
        if (q_valid && (head.op != dsdk_pkg::OP_LOAD)) begin
          state_next = dsdk_pkg::BK_FETCH;
        end
      end
      dsdk_pkg::BK_FETCH: begin
        state_next = dsdk_pkg::BK_SCAN;
      end
      dsdk_pkg::BK_SCAN: begin
        if (y == vmask) begin
          state_next = dsdk_pkg::BK_DRAIN;
        end
      end
      dsdk_pkg::BK_DRAIN: begin
        state_next = last_point ? dsdk_pkg::BK_IDLE : dsdk_pkg::BK_FETCH;
      end
      default: begin
        state_next = dsdk_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    we      = 1'b0;
    raddr_a = y;
    unique case (state)
      dsdk_pkg::BK_IDLE: begin
        pop = q_valid;
        we  = q_valid && (head.op == dsdk_pkg::OP_LOAD) && in_table;
      end
      dsdk_pkg::BK_FETCH: begin
        raddr_a = p;
      end
      dsdk_pkg::BK_SCAN: begin
        raddr_a = y;
      end
      dsdk_pkg::BK_DRAIN: begin
        raddr_a = y;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign waddr   = head.index[AW-1:0];
  assign wdata   = head.value[AW-1:0];
  assign raddr_b = p ^ y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dsdk_pkg::BK_IDLE;
      acc_v        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      acc_v        <= (state == dsdk_pkg::BK_SCAN);
      result_valid <= (state == dsdk_pkg::BK_DRAIN) && last_point;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.op != dsdk_pkg::OP_LOAD)) begin
      op    <= head.op;
      vmask <= head_vmask;
      marks <= head.marks;
      dom   <= '0;
      p     <= (head.op == dsdk_pkg::OP_SET) ? (head.index[AW-1:0] & head_vmask) : '0;
    end
    if (state == dsdk_pkg::BK_FETCH) begin
      y     <= '0;
      sbits <= '0;
    end else begin
      sbits <= sbits_upd;
    end
    if (state == dsdk_pkg::BK_SCAN) begin
      y <= y + AW'(1);
      if (y == '0) begin
        fp <= rdata_a;
      end
    end
    if (state == dsdk_pkg::BK_DRAIN) begin
      p   <= p + AW'(1);
      dom <= dom_upd;
      result_bitmap <= (op == dsdk_pkg::OP_SET) ? sbits_upd : dom_upd;
    end
  end

endmodule

// File: src/derivative_set_and_domain_kernel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// derivative_set_and_domain_kernel_top
// Truth table store with derivative value set and domain queries.
//
// Channel   Direction  Handshake                  Payload
// request   in         start / busy               mode, index, entry_value, t_set
// result    out        result_valid (1 cycle)     result_bitmap
// config    in         cfg_valid / cfg_ready      cfg_data (dimension)
//
// Steps, with n = 2^dimension: a load is written to the table as it is popped;
// a set query goes through fetch, a scan over y and drain. The scan reads one
// table pair per cycle from two table copies over the n values of y, and is
// repeated once per point for a domain query, each with its own fetch and drain.
// The result strobe comes in the cycle after the last drain.
// Reset is synchronous and clears the queue, the engine and the dimension
// (back to 6); the table holds garbage until loaded. busy is high only while
// the command queue is full; the receiver of results cannot stall.
//
// A domain query uses the fact that f(x)^f(y)^f(x^y) is symmetric over the
// triple {x, y, x^y}: position p belongs to the cover of t exactly when t is
// in the value set of p. So p is in the domain iff every marked t lies in the
// value set of p, and the engine runs one set scan per point.
// ----------------------------------------------------------------------------
module derivative_set_and_domain_kernel_top #(
  parameter int MAX_DIM     = 6,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dsdk_pkg::DIM_W-1:0] cfg_data,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 mode,
  input  logic [dsdk_pkg::IDX_W-1:0] index,
  input  logic [dsdk_pkg::IDX_W-1:0] entry_value,
  input  logic [dsdk_pkg::MAP_W-1:0] t_set,
  output logic                       result_valid,
  output logic [dsdk_pkg::MAP_W-1:0] result_bitmap
);

  logic           q_full;
  logic           q_valid;
  logic           push;
  logic           pop;
  dsdk_pkg::cmd_t push_cmd;
  dsdk_pkg::cmd_t head;

  // Front: take the transaction, clamp dimension, classify, queue
  dsdk_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .index       (index),
    .entry_value (entry_value),
    .t_set       (t_set),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Queue: hold commands while the engine is busy scanning
  dsdk_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (head)
  );

  // Back: execute loads and queries in order
  dsdk_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_bitmap (result_bitmap)
  );

`ifndef SYNTHESIS
  // Every query passes through fetch, scan and drain after idle, so results never come back to back
  a_result_spaced: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe on consecutive cycles");

  // The queue is empty after reset, so the block is ready at once
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> !busy)
    else $error("busy asserted right after reset");

  // No result can be pending out of reset
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result strobe right after reset");

  // Never pop an empty queue
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("command popped from empty queue");
`endif

endmodule

// File: dv/tb_derivative_set_and_domain_kernel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_derivative_set_and_domain_kernel_top
// Self-checking bench for the derivative set and domain kernel. It loads truth
// tables, runs set and domain queries under a sweep of dimension settings, and
// checks each result strobe against a behavioral predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_derivative_set_and_domain_kernel_top;

  // Mode 3 is not a command; the block must drop it without a result
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Loads give no strobe, so a load may still sit in the engine when the
  // last query result is seen; give it this many cycles before reconfiguring
  localparam int LOAD_SETTLE = 16;
  localparam int END_SETTLE  = 50;
  localparam int PHASE_ITEMS = 8;
  localparam int SWEEP_LEN   = 9;
  localparam int DRILL_LEN   = 20;

  // One row of the directed drill; want is used only when typed is set
  typedef struct {
    logic [1:0]                 op;
    logic [dsdk_pkg::IDX_W-1:0] idx;
    logic [dsdk_pkg::IDX_W-1:0] val;
    logic [dsdk_pkg::MAP_W-1:0] marks;
    bit                         typed;
    logic [dsdk_pkg::MAP_W-1:0] want;
  } drill_row_t;

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       cfg_valid   = 1'b0;
  logic                       cfg_ready;
  logic [dsdk_pkg::DIM_W-1:0] cfg_data    = '0;
  logic                       start       = 1'b0;
  logic                       busy;
  logic [1:0]                 mode        = dsdk_pkg::MODE_LOAD;
  logic [dsdk_pkg::IDX_W-1:0] index       = '0;
  logic [dsdk_pkg::IDX_W-1:0] entry_value = '0;
  logic [dsdk_pkg::MAP_W-1:0] t_set       = '0;
  logic                       result_valid;
  logic [dsdk_pkg::MAP_W-1:0] result_bitmap;

  // Bench copy of the block state
  logic [dsdk_pkg::IDX_W-1:0] fn_table [64];
  bit                         written  [64];
  logic [dsdk_pkg::DIM_W-1:0] dim_mirror = dsdk_pkg::DIM_RESET;

  // Bitmaps still owed by the block, oldest first
  logic [dsdk_pkg::MAP_W-1:0] pending_bitmaps [$];
  int                         mismatches = 0;
  bit                         gap_free   = 1'b0;

  always #4 clk = ~clk;

  derivative_set_and_domain_kernel_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .index         (index),
    .entry_value   (entry_value),
    .t_set         (t_set),
    .result_valid  (result_valid),
    .result_bitmap (result_bitmap)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Number of table points in use; dimension 0 acts as 1, 7 acts as 6
  function automatic int unsigned table_span();
    int unsigned d;
    d = dim_mirror;
    if (d < 1) begin
      d = 1;
    end
    if (d > 6) begin
      d = 6;
    end
    return 1 << d;
  endfunction

  function automatic logic [dsdk_pkg::MAP_W-1:0] span_mask(input int unsigned n);
    if (n >= dsdk_pkg::MAP_W) begin
      return '1;
    end
    return (dsdk_pkg::MAP_W'(1) << n) - dsdk_pkg::MAP_W'(1);
  endfunction

  // Bitmap of f(x)^f(y)^f(x^y) over every y; points and entries cut to span
  function automatic logic [dsdk_pkg::MAP_W-1:0] derivative_values_at(
    input logic [dsdk_pkg::IDX_W-1:0] x
  );
    int unsigned                n, vm, xm, y, t;
    logic [dsdk_pkg::MAP_W-1:0] seen;
    n    = table_span();
    vm   = n - 1;
    xm   = x & vm;
    seen = '0;
    for (y = 0; y < n; y++) begin
      t = (fn_table[xm] ^ fn_table[y] ^ fn_table[xm ^ y]) & vm;
      seen[t] = 1'b1;
    end
    return seen;
  endfunction

  // For every t, collect x, y and x^y of each pair hitting t in one pass,
  // then AND the collections of the marked t values
  function automatic logic [dsdk_pkg::MAP_W-1:0] domain_over_marks(
    input logic [dsdk_pkg::MAP_W-1:0] marks
  );
    logic [dsdk_pkg::MAP_W-1:0] reach [64];
    logic [dsdk_pkg::MAP_W-1:0] live, dom;
    int unsigned                n, vm, x, y, v, t;
    n  = table_span();
    vm = n - 1;
    for (t = 0; t < 64; t++) begin
      reach[t] = '0;
    end
    for (x = 0; x < n; x++) begin
      for (y = 0; y < n; y++) begin
        v = (fn_table[x] ^ fn_table[y] ^ fn_table[x ^ y]) & vm;
        reach[v][x]     = 1'b1;
        reach[v][y]     = 1'b1;
        reach[v][x ^ y] = 1'b1;
      end
    end
    live = marks & span_mask(n);
    dom  = span_mask(n);
    for (t = 0; t < n; t++) begin
      if (live[t]) begin
        dom &= reach[t];
      end
    end
    return dom;
  endfunction

  // Mix of empty, full, dense random, sparse, and sparse with garbage above span
  function automatic logic [dsdk_pkg::MAP_W-1:0] random_marks(input int unsigned n);
    logic [dsdk_pkg::MAP_W-1:0] m;
    logic [dsdk_pkg::MAP_W-1:0] one;
    one = dsdk_pkg::MAP_W'(1);
    case ($urandom_range(0, 5))
      0: m = '0;
      1: m = '1;
      2: m = {$urandom, $urandom};
      3: m = one << $urandom_range(0, n - 1);
      4: m = (one << $urandom_range(0, n - 1)) | (one << $urandom_range(0, n - 1));
      default: m = (one << $urandom_range(0, n - 1))
                   | ({$urandom, $urandom} & ~span_mask(n));
    endcase
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Present one command and hold it until a transaction happens, then update
  // the bench state. start stays high on return so a back-to-back command
  // needs no second assignment in this step.
  task automatic issue(input logic [1:0] m, input logic [dsdk_pkg::IDX_W-1:0] i,
                       input logic [dsdk_pkg::IDX_W-1:0] v,
                       input logic [dsdk_pkg::MAP_W-1:0] marks,
                       input bit typed, input logic [dsdk_pkg::MAP_W-1:0] want);
    start       <= 1'b1;
    mode        <= m;
    index       <= i;
    entry_value <= v;
    t_set       <= marks;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    case (m)
      dsdk_pkg::MODE_LOAD: begin
        fn_table[i] = v;
        written[i]  = 1'b1;
      end
      dsdk_pkg::MODE_SET: begin
        pending_bitmaps.push_back(typed ? want : derivative_values_at(i));
      end
      dsdk_pkg::MODE_DOMAIN: begin
        pending_bitmaps.push_back(typed ? want : domain_over_marks(marks));
      end
      default: begin
      end
    endcase
  endtask

  // Idle the request side about 31 times in 100; now and then for long enough
  // to leave the engine running empty in the middle of a scan
  task automatic pace();
    if (!gap_free && $urandom_range(0, 99) < 31) begin
      start <= 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(20, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Hold off until every owed result is in and any trailing load has retired,
  // then write the dimension register
  task automatic settle_and_configure(input logic [dsdk_pkg::DIM_W-1:0] d);
    start <= 1'b0;
    while (pending_bitmaps.size() != 0) begin
      @(posedge clk);
    end
    repeat (LOAD_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid  <= 1'b0;
    dim_mirror = d;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: a strobe is a transaction at the edge that ends its cycle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    logic [dsdk_pkg::MAP_W-1:0] want;
    if (!rst && result_valid) begin
      if (pending_bitmaps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result_bitmap);
        mismatches++;
      end else begin
        want = pending_bitmaps.pop_front();
        if (result_bitmap !== want) begin
          $display("%0t: result_bitmap mismatch, expected %h, actual %h",
                   $time, want, result_bitmap);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    drill_row_t                 plan [DRILL_LEN];
    logic [dsdk_pkg::DIM_W-1:0] dim_sweep [SWEEP_LEN];
    int unsigned                ph, k, p, n, pick, style, shift;
    logic [dsdk_pkg::IDX_W-1:0] fill;

    // Directed drill under dimension 2 (four points). The first block runs on
    // an all-zero function, so every derivative is 0: set queries give bit 0
    // alone, the empty t bitmap and t = 0 give the full domain, and any other
    // marked t empties it. Wide entry values and points, ignored t bits above
    // the span and the unknown mode come next; the rest goes to the predictor.
    plan = '{
      '{dsdk_pkg::MODE_LOAD,   6'd0,  6'd0,  64'h0,                  1'b0, 64'h0},
      '{dsdk_pkg::MODE_LOAD,   6'd1,  6'd0,  64'h0,                  1'b0, 64'h0},
      '{dsdk_pkg::MODE_LOAD,   6'd2,  6'd0,  64'h0,                  1'b0, 64'h0},
      // only the low bits of a loaded value count in a query
      '{dsdk_pkg::MODE_LOAD,   6'd3,  6'h3C, 64'h0,                  1'b0, 64'h0},
      '{dsdk_pkg::MODE_SET,    6'd0,  6'd0,  64'h0,                  1'b1, 64'h1},
      // point 63 folds down to point 3
      '{dsdk_pkg::MODE_SET,    6'd63, 6'd0,  64'h0,                  1'b1, 64'h1},
      '{dsdk_pkg::MODE_DOMAIN, 6'd0,  6'd0,  64'h0,                  1'b1, 64'hF},
      '{dsdk_pkg::MODE_DOMAIN, 6'd0,  6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
      '{dsdk_pkg::MODE_DOMAIN, 6'd0,  6'd0,  64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 64'hF},
      '{dsdk_pkg::MODE_DOMAIN, 6'd0,  6'd0,  64'h1,                  1'b1, 64'hF},
      '{MODE_NONE,             6'd5,  6'd7,  64'h1234_5678_9ABC_DEF0, 1'b0, 64'h0},
      '{dsdk_pkg::MODE_LOAD,   6'd1,  6'd63, 64'h0,                  1'b0, 64'h0},
      '{dsdk_pkg::MODE_LOAD,   6'd2,  6'd1,  64'h0,                  1'b0, 64'h0},
      '{dsdk_pkg::MODE_LOAD,   6'd3,  6'd2,  64'h0,                  1'b0, 64'h0},
      '{dsdk_pkg::MODE_SET,    6'd1,  6'd0,  64'h0,                  1'b0, 64'h0},
      '{dsdk_pkg::MODE_SET,    6'd2,  6'd0,  64'h0,                  1'b0, 64'h0},
      '{dsdk_pkg::MODE_DOMAIN, 6'd0,  6'd0,  64'h5,                  1'b0, 64'h0},
      '{dsdk_pkg::MODE_DOMAIN, 6'd0,  6'd0,  64'h8000_0000_0000_0000, 1'b1, 64'hF},
      '{dsdk_pkg::MODE_LOAD,   6'd63, 6'd63, 64'h0,                  1'b0, 64'h0},
      '{dsdk_pkg::MODE_SET,    6'd3,  6'd0,  64'h0,                  1'b0, 64'h0}
    };

    // Out-of-range settings 0 and 7 sit between legal ones; the big spans
    // come late so the table is mostly loaded by then
    dim_sweep = '{3'd1, 3'd0, 3'd3, 3'd2, 3'd5, 3'd4, 3'd7, 3'd6, 3'd3};

    for (p = 0; p < 64; p++) begin
      fn_table[p] = '0;
      written[p]  = 1'b0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    settle_and_configure(3'd2);
    for (k = 0; k < DRILL_LEN; k++) begin
      pace();
      issue(plan[k].op, plan[k].idx, plan[k].val, plan[k].marks, plan[k].typed, plan[k].want);
    end

    // Random phases: one dimension each, written only once the block is idle
    for (ph = 0; ph < SWEEP_LEN; ph++) begin
      settle_and_configure(dim_sweep[ph]);
      // keep one whole phase free of gaps to run commands back to back
      gap_free = (ph == 3);
      n        = table_span();

      // Load every point not yet written before any query may read it;
      // some phases get affine or quadratic-like entries instead of noise
      style = $urandom_range(0, 2);
      shift = $urandom_range(0, 63);
      for (p = 0; p < n; p++) begin
        if (!written[p]) begin
          case (style)
            0:       fill = dsdk_pkg::IDX_W'($urandom_range(0, 63));
            1:       fill = dsdk_pkg::IDX_W'(p ^ shift);
            default: fill = dsdk_pkg::IDX_W'(p * p + shift);
          endcase
          pace();
          issue(dsdk_pkg::MODE_LOAD, dsdk_pkg::IDX_W'(p), fill, {$urandom, $urandom},
                1'b0, '0);
        end
      end

      for (k = 0; k < PHASE_ITEMS; k++) begin
        pace();
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
          issue(dsdk_pkg::MODE_LOAD, dsdk_pkg::IDX_W'($urandom_range(0, 63)),
                dsdk_pkg::IDX_W'($urandom_range(0, 63)), {$urandom, $urandom}, 1'b0, '0);
        end else if (pick < 58) begin
          issue(dsdk_pkg::MODE_SET, dsdk_pkg::IDX_W'($urandom_range(0, 63)),
                dsdk_pkg::IDX_W'($urandom_range(0, 63)), {$urandom, $urandom}, 1'b0, '0);
        end else if (pick < 95) begin
          issue(dsdk_pkg::MODE_DOMAIN, dsdk_pkg::IDX_W'($urandom_range(0, 63)),
                dsdk_pkg::IDX_W'($urandom_range(0, 63)), random_marks(n), 1'b0, '0);
        end else begin
          issue(MODE_NONE, dsdk_pkg::IDX_W'($urandom_range(0, 63)),
                dsdk_pkg::IDX_W'($urandom_range(0, 63)), {$urandom, $urandom}, 1'b0, '0);
        end
      end
    end

    // Drain, then watch a while longer for stray strobes
    start <= 1'b0;
    while (pending_bitmaps.size() != 0) begin
      @(posedge clk);
    end
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_derivative_set_and_domain_kernel_top: PASS");
    end else begin
      $display("tb_derivative_set_and_domain_kernel_top: FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #6_000_000;
    $display("tb_derivative_set_and_domain_kernel_top: FAIL");
    $finish;
  end

endmodule
